### hdl/snfcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer - shared definitions
// Opcodes, item codes, geometry constants and the result entry type used by
// the sequencer.
// ----------------------------------------------------------------------------
package snfcs_pkg;

  // Flash geometry. PAGE_BYTES must be a power of two.
  localparam int unsigned PAGE_BYTES   = 256;
  localparam int unsigned ADDRESS_BITS = 24;
  localparam int unsigned PageAw       = $clog2(PAGE_BYTES);
  localparam int unsigned PageCw       = PageAw + 1;

  // Result queue geometry.
  localparam int unsigned MaxResults = 6;
  localparam int unsigned QDepth     = 16;
  localparam int unsigned QAw        = $clog2(QDepth);
  localparam int unsigned QCw        = QAw + 1;
  localparam int unsigned NumW       = $clog2(MaxResults + 1);

  // Flash opcodes and fixed bytes.
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_PP    = 8'h02;
  localparam logic [7:0] OP_SE    = 8'h20;
  localparam logic [7:0] OP_JEDEC = 8'h9F;
  localparam logic [7:0] DUMMY    = 8'hFF;

  // Input item modes.
  localparam logic [1:0] MODE_CMD   = 2'd0;
  localparam logic [1:0] MODE_HOST  = 2'd1;
  localparam logic [1:0] MODE_FLASH = 2'd2;

  // Host commands.
  localparam logic [1:0] CMD_READ_ID = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_PROGRAM = 2'd2;
  localparam logic [1:0] CMD_ERASE   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_XFER = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        frame_start;
    logic        frame_end;
    logic        expect_reply;
    logic [23:0] host_data;
    logic        last;
  } res_t;

  // A serial byte transfer.
  function automatic res_t mk_xfer(logic [7:0] tx, logic fs, logic fe, logic er);
    res_t r;
    r              = '0;
    r.kind         = KIND_XFER;
    r.tx_byte      = tx;
    r.frame_start  = fs;
    r.frame_end    = fe;
    r.expect_reply = er;
    return r;
  endfunction

  // A data or completion item for the host.
  function automatic res_t mk_note(logic [1:0] kind, logic [23:0] data);
    res_t r;
    r           = '0;
    r.kind      = kind;
    r.host_data = data;
    return r;
  endfunction

  // Bytes that fit from the address up to the page end, capped by the remainder.
  function automatic logic [PageCw-1:0] page_fill(logic [ADDRESS_BITS-1:0] addr,
                                                  logic [15:0] rem);
    logic [PageCw-1:0] room;
    room = PageCw'(PAGE_BYTES) - {1'b0, addr[PageAw-1:0]};
    if (rem < 16'(room)) begin
      return PageCw'(rem);
    end
    return room;
  endfunction

endpackage

### hdl/spi_nor_flash_command_sequencer.sv
`timescale 1ns / 1ps
// The results of an accepted item are registered into the result queue and offered from its head.
// Throughput: an input item can be taken every cycle while the result queue has room
// for six entries; results leave at one per cycle while the output is ready, so output draining sets the rate.
// Each input yields zero to six results, all computed in the accepting cycle.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties the queue.
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Expands host commands and received flash bytes into serial byte transfers,
// host data items and completion items, queued for the output stream.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // command[1:0], address[25:2], length[41:26], host_byte[49:42], flash_byte[57:50]
  input  logic [63:0] s_axis_tdata_i,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tx_byte[7:0], frame_start[8], frame_end[9], expect_reply[10], host_data[34:11]
  output logic [39:0] m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned AddrW  = snfcs_pkg::ADDRESS_BITS;
  localparam int unsigned PageCw = snfcs_pkg::PageCw;
  localparam int unsigned QAw    = snfcs_pkg::QAw;
  localparam int unsigned QCw    = snfcs_pkg::QCw;
  localparam int unsigned NumW   = snfcs_pkg::NumW;
  localparam int unsigned NRes   = snfcs_pkg::MaxResults;

  // Sequencer phases.
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_ID          = 4'd1;
  localparam logic [3:0] PH_READ        = 4'd2;
  localparam logic [3:0] PH_PROG        = 4'd3;
  localparam logic [3:0] PH_PROG_POLL   = 4'd4;
  localparam logic [3:0] PH_ERASE_POLL1 = 4'd5;
  localparam logic [3:0] PH_ERASE_POLL2 = 4'd6;

  // Input fields.
  logic [1:0]  mode;
  logic [1:0]  command;
  logic [23:0] address;
  logic [15:0] length;
  logic [7:0]  host_byte;
  logic [7:0]  flash_byte;

  assign mode       = s_axis_tuser_i;
  assign command    = s_axis_tdata_i[1:0];
  assign address    = s_axis_tdata_i[25:2];
  assign length     = s_axis_tdata_i[41:26];
  assign host_byte  = s_axis_tdata_i[49:42];
  assign flash_byte = s_axis_tdata_i[57:50];

  // Sequencer state.
  logic [3:0]        phase_q, phase_d;
  logic [1:0]        act_cmd_q, act_cmd_d;
  logic [AddrW-1:0]  cur_addr_q, cur_addr_d;
  logic [15:0]       bytes_rem_q, bytes_rem_d;
  logic [PageCw-1:0] page_left_q, page_left_d;
  logic [23:0]       id_acc_q, id_acc_d;
  logic [1:0]        reply_cnt_q, reply_cnt_d;

  // Result queue.
  snfcs_pkg::res_t   queue_q [snfcs_pkg::QDepth];
  logic [QAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCw-1:0]    count_q;

  logic              in_fire;
  logic              out_fire;
  snfcs_pkg::res_t   res [NRes];
  logic [NumW-1:0]   n_res;

  logic [AddrW-1:0]  addr_in;
  logic [23:0]       a24_in;
  logic [23:0]       a24_cur;
  logic [15:0]       rem_dec;
  logic [1:0]        reply_inc;
  logic [23:0]       id_next;
  logic              page_end;

  // Accept while six queue entries are guaranteed free.
  assign s_axis_tready_o = (count_q <= QCw'(snfcs_pkg::QDepth - NRes));
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_fire        = m_axis_tvalid_o & m_axis_tready_i;

  assign addr_in   = AddrW'(address);
  assign a24_in    = 24'(addr_in);
  assign a24_cur   = 24'(cur_addr_q);
  assign rem_dec   = bytes_rem_q - 16'd1;
  assign reply_inc = reply_cnt_q + 2'd1;
  assign id_next   = {id_acc_q[15:0], flash_byte};
  assign page_end  = (page_left_q <= PageCw'(1));

  // Next state and the result list of the item in transfer.
  always_comb begin
    phase_d     = phase_q;
    act_cmd_d   = act_cmd_q;
    cur_addr_d  = cur_addr_q;
    bytes_rem_d = bytes_rem_q;
    page_left_d = page_left_q;
    id_acc_d    = id_acc_q;
    reply_cnt_d = reply_cnt_q;
    n_res       = '0;
    for (int i = 0; i < NRes; i++) begin
      res[i] = '0;
    end

    if (in_fire) begin
      case (mode)
        snfcs_pkg::MODE_CMD: begin
          if (phase_q == PH_IDLE) begin
            act_cmd_d   = command;
            cur_addr_d  = addr_in;
            bytes_rem_d = length;
            case (command)
              snfcs_pkg::CMD_READ_ID: begin
                id_acc_d    = '0;
                reply_cnt_d = '0;
                res[0] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_JEDEC, 1'b1, 1'b0, 1'b0);
                res[1] = snfcs_pkg::mk_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b0, 1'b1);
                res[2] = snfcs_pkg::mk_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b0, 1'b1);
                res[3] = snfcs_pkg::mk_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b1, 1'b1);
                n_res   = NumW'(4);
                phase_d = PH_ID;
              end
              snfcs_pkg::CMD_READ: begin
                if (length == 16'd0) begin
                  res[0] = snfcs_pkg::mk_note(snfcs_pkg::KIND_DONE, 24'd0);
                  n_res  = NumW'(1);
                end else begin
                  res[0] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_READ, 1'b1, 1'b0, 1'b0);
                  res[1] = snfcs_pkg::mk_xfer(a24_in[23:16], 1'b0, 1'b0, 1'b0);
                  res[2] = snfcs_pkg::mk_xfer(a24_in[15:8], 1'b0, 1'b0, 1'b0);
                  res[3] = snfcs_pkg::mk_xfer(a24_in[7:0], 1'b0, 1'b0, 1'b0);
                  res[4] = snfcs_pkg::mk_xfer(snfcs_pkg::DUMMY, 1'b0,
                                              (length == 16'd1), 1'b1);
                  n_res   = NumW'(5);
                  phase_d = PH_READ;
                end
              end
              snfcs_pkg::CMD_PROGRAM: begin
                if (length == 16'd0) begin
                  res[0] = snfcs_pkg::mk_note(snfcs_pkg::KIND_DONE, 24'd0);
                  n_res  = NumW'(1);
                end else begin
                  page_left_d = snfcs_pkg::page_fill(addr_in, length);
                  res[0] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
                  res[1] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_PP, 1'b1, 1'b0, 1'b0);
                  res[2] = snfcs_pkg::mk_xfer(a24_in[23:16], 1'b0, 1'b0, 1'b0);
                  res[3] = snfcs_pkg::mk_xfer(a24_in[15:8], 1'b0, 1'b0, 1'b0);
                  res[4] = snfcs_pkg::mk_xfer(a24_in[7:0], 1'b0, 1'b0, 1'b0);
                  n_res   = NumW'(5);
                  phase_d = PH_PROG;
                end
              end
              default: begin
                // Sector erase: write enable, then wait for the flash to go idle.
                res[0] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
                res[1] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
                res[2] = snfcs_pkg::mk_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b1, 1'b1);
                n_res   = NumW'(3);
                phase_d = PH_ERASE_POLL1;
              end
            endcase
          end
        end

        snfcs_pkg::MODE_HOST: begin
          if (phase_q == PH_PROG) begin
            res[0]      = snfcs_pkg::mk_xfer(host_byte, 1'b0, page_end, 1'b0);
            n_res       = NumW'(1);
            cur_addr_d  = cur_addr_q + AddrW'(1);
            bytes_rem_d = rem_dec;
            page_left_d = page_left_q - PageCw'(1);
            if (page_end) begin
              page_left_d = '0;
              res[1] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
              res[2] = snfcs_pkg::mk_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b1, 1'b1);
              n_res   = NumW'(3);
              phase_d = PH_PROG_POLL;
            end
          end
        end

        snfcs_pkg::MODE_FLASH: begin
          case (phase_q)
            PH_ID: begin
              id_acc_d    = id_next;
              reply_cnt_d = reply_inc;
              if (reply_inc == 2'd3) begin
                res[0] = snfcs_pkg::mk_note(snfcs_pkg::KIND_DATA, id_next);
                res[1] = snfcs_pkg::mk_note(snfcs_pkg::KIND_DONE, 24'd0);
                n_res       = NumW'(2);
                reply_cnt_d = '0;
                phase_d     = PH_IDLE;
              end
            end
            PH_READ: begin
              bytes_rem_d = rem_dec;
              res[0] = snfcs_pkg::mk_note(snfcs_pkg::KIND_DATA, 24'(flash_byte));
              n_res  = NumW'(2);
              if (rem_dec == 16'd0) begin
                res[1]  = snfcs_pkg::mk_note(snfcs_pkg::KIND_DONE, 24'd0);
                phase_d = PH_IDLE;
              end else begin
                res[1] = snfcs_pkg::mk_xfer(snfcs_pkg::DUMMY, 1'b0,
                                            (rem_dec == 16'd1), 1'b1);
              end
            end
            PH_PROG_POLL, PH_ERASE_POLL1, PH_ERASE_POLL2: begin
              if (flash_byte[0]) begin
                // Still busy: poll the status register again.
                res[0] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
                res[1] = snfcs_pkg::mk_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b1, 1'b1);
                n_res  = NumW'(2);
              end else if (phase_q == PH_PROG_POLL) begin
                if (bytes_rem_q == 16'd0) begin
                  res[0]  = snfcs_pkg::mk_note(snfcs_pkg::KIND_DONE, 24'd0);
                  n_res   = NumW'(1);
                  phase_d = PH_IDLE;
                end else begin
                  page_left_d = snfcs_pkg::page_fill(cur_addr_q, bytes_rem_q);
                  res[0] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
                  res[1] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_PP, 1'b1, 1'b0, 1'b0);
                  res[2] = snfcs_pkg::mk_xfer(a24_cur[23:16], 1'b0, 1'b0, 1'b0);
                  res[3] = snfcs_pkg::mk_xfer(a24_cur[15:8], 1'b0, 1'b0, 1'b0);
                  res[4] = snfcs_pkg::mk_xfer(a24_cur[7:0], 1'b0, 1'b0, 1'b0);
                  n_res   = NumW'(5);
                  phase_d = PH_PROG;
                end
              end else if (phase_q == PH_ERASE_POLL1) begin
                res[0] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_SE, 1'b1, 1'b0, 1'b0);
                res[1] = snfcs_pkg::mk_xfer(a24_cur[23:16], 1'b0, 1'b0, 1'b0);
                res[2] = snfcs_pkg::mk_xfer(a24_cur[15:8], 1'b0, 1'b0, 1'b0);
                res[3] = snfcs_pkg::mk_xfer(a24_cur[7:0], 1'b0, 1'b1, 1'b0);
                res[4] = snfcs_pkg::mk_xfer(snfcs_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
                res[5] = snfcs_pkg::mk_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b1, 1'b1);
                n_res   = NumW'(6);
                phase_d = PH_ERASE_POLL2;
              end else begin
                res[0]  = snfcs_pkg::mk_note(snfcs_pkg::KIND_DONE, 24'd0);
                n_res   = NumW'(1);
                phase_d = PH_IDLE;
              end
            end
            default: begin
              // No reply is pending: the byte is dropped.
            end
          endcase
        end

        default: begin
          // Unused mode: dropped.
        end
      endcase
    end

    // Flag the final result of the item.
    for (int i = 0; i < NRes; i++) begin
      if (NumW'(i + 1) == n_res) begin
        res[i].last = 1'b1;
      end
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      act_cmd_q   <= '0;
      cur_addr_q  <= '0;
      bytes_rem_q <= '0;
      page_left_q <= '0;
      id_acc_q    <= '0;
      reply_cnt_q <= '0;
    end else begin
      phase_q     <= phase_d;
      act_cmd_q   <= act_cmd_d;
      cur_addr_q  <= cur_addr_d;
      bytes_rem_q <= bytes_rem_d;
      page_left_q <= page_left_d;
      id_acc_q    <= id_acc_d;
      reply_cnt_q <= reply_cnt_d;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QAw'(n_res);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QAw'(1);
      end
      count_q <= count_q + QCw'(n_res) - QCw'(out_fire);
    end
  end

  // Queue storage: the item's results land in consecutive entries.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NRes; i++) begin
      if (NumW'(i) < n_res) begin
        queue_q[wr_ptr_q + QAw'(i)] <= res[i];
      end
    end
  end

  // Output stream from the queue head.
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tuser_o  = queue_q[rd_ptr_q].kind;
  assign m_axis_tlast_o  = queue_q[rd_ptr_q].last;
  assign m_axis_tdata_o  = {5'b0,
                            queue_q[rd_ptr_q].host_data,
                            queue_q[rd_ptr_q].expect_reply,
                            queue_q[rd_ptr_q].frame_end,
                            queue_q[rd_ptr_q].frame_start,
                            queue_q[rd_ptr_q].tx_byte};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer - self-checking testbench
// Drives host commands, host write bytes and flash status/data bytes into the
// sequencer and checks every result transfer against a cycle-free model of
// the command flow. A directed opening covers the corner cases, then random
// command sequences run with random idling on the input and back-pressure on the results.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_ITEMS     = 135;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLE_LIMIT      = 200_000;

  // Input mode that the sequencer never acts on.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Write-in-progress bit of the flash status register.
  localparam logic [7:0] BUSY_MASK   = 8'h01;

  // Where the sequencer stands in a command.
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_ID_REPLY,
    SEQ_READ_DATA,
    SEQ_PROG_DATA,
    SEQ_PROG_WAIT,
    SEQ_ERASE_PRE_WAIT,
    SEQ_ERASE_POST_WAIT
  } seq_state_e;

  // One input transfer, unpacked.
  typedef struct {
    logic [1:0]  mode;
    logic [1:0]  cmd;
    logic [23:0] addr;
    logic [15:0] len;
    logic [7:0]  host_byte;
    logic [7:0]  flash_byte;
  } flash_req_t;

  // Tracks the command flow and holds the result transfers still to come.
  class flash_seq_scoreboard;
    seq_state_e        phase = SEQ_IDLE;
    logic [23:0]       cur_addr;
    logic [15:0]       bytes_left;
    logic [8:0]        page_left;
    logic [23:0]       id_word;
    logic [1:0]        id_bytes;
    snfcs_pkg::res_t   expected_q[$];
    snfcs_pkg::res_t   batch[$];
    int                errors;
    int                checked;
    int                items;
    int                ignored;
    int                busy_polls;
    int                cmd_seen[4];

    // True when the sequencer drops an item of this mode in its present state.
    function bit ignores(logic [1:0] mode);
      case (mode)
        snfcs_pkg::MODE_CMD:   return phase != SEQ_IDLE;
        snfcs_pkg::MODE_HOST:  return phase != SEQ_PROG_DATA;
        snfcs_pkg::MODE_FLASH: return phase == SEQ_IDLE || phase == SEQ_PROG_DATA;
        default:               return 1'b1;
      endcase
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] tx, bit fs, bit fe, bit er,
                       logic [23:0] data);
      snfcs_pkg::res_t r;
      r              = '0;
      r.kind         = kind;
      r.tx_byte      = tx;
      r.frame_start  = fs;
      r.frame_end    = fe;
      r.expect_reply = er;
      r.host_data    = data;
      batch.push_back(r);
    endfunction

    function void emit_xfer(logic [7:0] tx, bit fs, bit fe, bit er);
      emit(snfcs_pkg::KIND_XFER, tx, fs, fe, er, 24'h0);
    endfunction

    // Opcode followed by the address, high byte first.
    function void emit_addr_frame(logic [7:0] op, bit fe_last);
      emit_xfer(op, 1'b1, 1'b0, 1'b0);
      emit_xfer(cur_addr[23:16], 1'b0, 1'b0, 1'b0);
      emit_xfer(cur_addr[15:8], 1'b0, 1'b0, 1'b0);
      emit_xfer(cur_addr[7:0], 1'b0, fe_last, 1'b0);
    endfunction

    // Read-status frame whose second byte brings the status back.
    function void emit_status_poll();
      emit_xfer(snfcs_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
      emit_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b1, 1'b1);
    endfunction

    // Write enable and program header; the page chunk runs up to the page end.
    function void start_page();
      int unsigned room;
      room = snfcs_pkg::PAGE_BYTES - (cur_addr % snfcs_pkg::PAGE_BYTES);
      page_left = (32'(bytes_left) < room) ? 9'(bytes_left) : 9'(room);
      emit_xfer(snfcs_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
      emit_addr_frame(snfcs_pkg::OP_PP, 1'b0);
    endfunction

    function void finish_command();
      emit(snfcs_pkg::KIND_DONE, 8'h00, 1'b0, 1'b0, 1'b0, 24'h0);
      phase = SEQ_IDLE;
    endfunction

    // Works out the results of an accepted input transfer.
    function void note_input(flash_req_t q);
      snfcs_pkg::res_t tail;
      bit              page_done;
      batch.delete();
      items++;
      if (ignores(q.mode)) ignored++;
      case (q.mode)
        snfcs_pkg::MODE_CMD: if (phase == SEQ_IDLE) begin
          cur_addr   = q.addr;
          bytes_left = q.len;
          cmd_seen[q.cmd]++;
          case (q.cmd)
            snfcs_pkg::CMD_READ_ID: begin
              id_word  = '0;
              id_bytes = '0;
              emit_xfer(snfcs_pkg::OP_JEDEC, 1'b1, 1'b0, 1'b0);
              emit_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b0, 1'b1);
              emit_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b0, 1'b1);
              emit_xfer(snfcs_pkg::DUMMY, 1'b0, 1'b1, 1'b1);
              phase = SEQ_ID_REPLY;
            end
            snfcs_pkg::CMD_READ: begin
              if (q.len == 16'd0) begin
                finish_command();
              end else begin
                emit_addr_frame(snfcs_pkg::OP_READ, 1'b0);
                emit_xfer(snfcs_pkg::DUMMY, 1'b0, q.len == 16'd1, 1'b1);
                phase = SEQ_READ_DATA;
              end
            end
            snfcs_pkg::CMD_PROGRAM: begin
              if (q.len == 16'd0) begin
                finish_command();
              end else begin
                start_page();
                phase = SEQ_PROG_DATA;
              end
            end
            default: begin
              emit_xfer(snfcs_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
              emit_status_poll();
              phase = SEQ_ERASE_PRE_WAIT;
            end
          endcase
        end
        snfcs_pkg::MODE_HOST: if (phase == SEQ_PROG_DATA) begin
          page_done = page_left <= 9'd1;
          emit_xfer(q.host_byte, 1'b0, page_done, 1'b0);
          cur_addr   = cur_addr + 24'd1;
          bytes_left = bytes_left - 16'd1;
          page_left  = page_left - 9'd1;
          if (page_done) begin
            page_left = '0;
            emit_status_poll();
            phase = SEQ_PROG_WAIT;
          end
        end
        snfcs_pkg::MODE_FLASH: begin
          case (phase)
            SEQ_ID_REPLY: begin
              id_word  = {id_word[15:0], q.flash_byte};
              id_bytes = id_bytes + 2'd1;
              if (id_bytes == 2'd3) begin
                emit(snfcs_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0, 1'b0, id_word);
                id_bytes = '0;
                finish_command();
              end
            end
            SEQ_READ_DATA: begin
              emit(snfcs_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0, 1'b0,
                   {16'h0, q.flash_byte});
              bytes_left = bytes_left - 16'd1;
              if (bytes_left == 16'd0) begin
                finish_command();
              end else begin
                emit_xfer(snfcs_pkg::DUMMY, 1'b0, bytes_left == 16'd1, 1'b1);
              end
            end
            SEQ_PROG_WAIT, SEQ_ERASE_PRE_WAIT, SEQ_ERASE_POST_WAIT: begin
              if ((q.flash_byte & BUSY_MASK) != 8'h00) begin
                busy_polls++;
                emit_status_poll();
              end else if (phase == SEQ_PROG_WAIT) begin
                if (bytes_left == 16'd0) begin
                  finish_command();
                end else begin
                  start_page();
                  phase = SEQ_PROG_DATA;
                end
              end else if (phase == SEQ_ERASE_PRE_WAIT) begin
                emit_addr_frame(snfcs_pkg::OP_SE, 1'b1);
                emit_status_poll();
                phase = SEQ_ERASE_POST_WAIT;
              end else begin
                finish_command();
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      // The final result of this input carries the last flag.
      if (batch.size() > 0) begin
        tail      = batch.pop_back();
        tail.last = 1'b1;
        batch.push_back(tail);
        foreach (batch[i]) expected_q.push_back(batch[i]);
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares a result transfer with the oldest expectation.
    function void check_result(snfcs_pkg::res_t got);
      snfcs_pkg::res_t want;
      if (expected_q.size() == 0) begin
        $error("Unexpected result: kind %0d, tx_byte 0x%02h, host_data 0x%06h",
               got.kind, got.tx_byte, got.host_data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("kind", want.kind, got.kind);
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("frame_start", want.frame_start, got.frame_start);
      compare_field("frame_end", want.frame_end, got.frame_end);
      compare_field("expect_reply", want.expect_reply, got.expect_reply);
      compare_field("host_data", want.host_data, got.host_data);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  flash_seq_scoreboard sb;
  bit          long_hold_req;
  int          eager_left;
  int          cycle_count;

  spi_nor_flash_command_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Run-time guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited.",
               cycle_count, sb.expected_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Idle stretch: mostly short, now and then long.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Result stream: random back-pressure, steady stretches and one long hold-off.
  initial begin
    int stall_left;
    int cyc;
    bit steady;
    stall_left      = 0;
    cyc             = 0;
    steady          = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) steady = $urandom_range(0, 3) == 0;
      if (long_hold_req) begin
        m_axis_tready_i = 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i = 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = gap_length();
      end
    end
  end

  // Every accepted result transfer is checked.
  always @(posedge clk_i) begin
    snfcs_pkg::res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got              = '0;
      got.kind         = m_axis_tuser_o;
      got.tx_byte      = m_axis_tdata_o[7:0];
      got.frame_start  = m_axis_tdata_o[8];
      got.frame_end    = m_axis_tdata_o[9];
      got.expect_reply = m_axis_tdata_o[10];
      got.host_data    = m_axis_tdata_o[34:11];
      got.last         = m_axis_tlast_o;
      sb.check_result(got);
    end
  end

  function automatic flash_req_t make_req(logic [1:0] mode, logic [1:0] cmd,
                                          logic [23:0] addr, logic [15:0] len,
                                          logic [7:0] host_byte,
                                          logic [7:0] flash_byte);
    flash_req_t q;
    q.mode       = mode;
    q.cmd        = cmd;
    q.addr       = addr;
    q.len        = len;
    q.host_byte  = host_byte;
    q.flash_byte = flash_byte;
    return q;
  endfunction

  task automatic pause_sender(int n);
    if (n > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Offers one transfer, notes it once accepted, then idles at random.
  task automatic send_item(flash_req_t q);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {6'b0, q.flash_byte, q.host_byte, q.len, q.addr, q.cmd};
    s_axis_tuser_i  = q.mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(q);
    if (eager_left > 0) begin
      eager_left--;
    end else if ($urandom_range(0, 99) < 40) begin
      pause_sender(gap_length());
    end
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic wait_for_drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Random transfer suited to the present state, with some noise mixed in.
  function automatic flash_req_t next_request();
    flash_req_t q;
    int r;
    q = make_req(snfcs_pkg::MODE_CMD, 2'($urandom), 24'($urandom), 16'($urandom),
                 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 99) < 8) begin
      do q.mode = 2'($urandom_range(0, 3)); while (!sb.ignores(q.mode));
      return q;
    end
    case (sb.phase)
      SEQ_IDLE: begin
        q.mode = snfcs_pkg::MODE_CMD;
        r = $urandom_range(0, 99);
        if (r >= 80) q.addr = {16'hFFFF, q.addr[7:0]};
        else if (r >= 40) q.addr[7:0] = 8'($urandom_range(240, 255));
        if (q.cmd == snfcs_pkg::CMD_READ) begin
          q.len = ($urandom_range(0, 99) < 8) ? 16'd0 : 16'($urandom_range(1, 12));
        end else if (q.cmd == snfcs_pkg::CMD_PROGRAM) begin
          q.len = ($urandom_range(0, 99) < 8) ? 16'd0 : 16'($urandom_range(1, 24));
        end
      end
      SEQ_PROG_DATA: q.mode = snfcs_pkg::MODE_HOST;
      SEQ_ID_REPLY, SEQ_READ_DATA: q.mode = snfcs_pkg::MODE_FLASH;
      default: begin
        q.mode = snfcs_pkg::MODE_FLASH;
        if ($urandom_range(0, 99) < 30) q.flash_byte = q.flash_byte | BUSY_MASK;
        else q.flash_byte = q.flash_byte & ~BUSY_MASK;
      end
    endcase
    return q;
  endfunction

  // Stimulus and end of run.
  initial begin
    int rand_done;
    int step;
    flash_req_t q;
    sb              = new;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = snfcs_pkg::MODE_CMD;
    long_hold_req   = 1'b0;
    eager_left      = 0;
    cycle_count     = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Read ID with a stray host byte in the middle of the replies.
    send_item(make_req(snfcs_pkg::MODE_CMD, snfcs_pkg::CMD_READ_ID,
                       24'hABCDEF, 16'hFFFF, 8'hFF, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_ERASE,
                       24'h000000, 16'h0000, 8'h00, 8'hEF));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ,
                       24'hFFFFFF, 16'h0000, 8'h00, 8'h40));
    send_item(make_req(snfcs_pkg::MODE_HOST, snfcs_pkg::CMD_PROGRAM,
                       24'h5A5A5A, 16'h1234, 8'h3C, 8'hFF));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'h00, 8'h18));
    // Zero-length read and program finish at once.
    send_item(make_req(snfcs_pkg::MODE_CMD, snfcs_pkg::CMD_READ,
                       24'h000000, 16'h0000, 8'h00, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_CMD, snfcs_pkg::CMD_PROGRAM,
                       24'hFFFFFF, 16'h0000, 8'h00, 8'h00));
    // Single-byte read at the top address.
    send_item(make_req(snfcs_pkg::MODE_CMD, snfcs_pkg::CMD_READ,
                       24'hFFFFFF, 16'd1, 8'h00, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ,
                       24'h000000, 16'h0000, 8'h00, 8'hFF));
    // Program across the page end and the address wrap, with a busy status.
    send_item(make_req(snfcs_pkg::MODE_CMD, snfcs_pkg::CMD_PROGRAM,
                       24'hFFFFFE, 16'd3, 8'h00, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_PROGRAM,
                       24'h000000, 16'h0000, 8'h00, 8'h01));
    send_item(make_req(snfcs_pkg::MODE_HOST, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'hFF, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_HOST, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'h00, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'h00, 8'h01));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'h00, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_HOST, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'hA5, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'h00, 8'hFE));
    // Erase, with a command and an unused mode offered while it is busy.
    send_item(make_req(snfcs_pkg::MODE_CMD, snfcs_pkg::CMD_ERASE,
                       24'h123456, 16'h8000, 8'h00, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_CMD, snfcs_pkg::CMD_READ,
                       24'h000010, 16'd4, 8'h00, 8'h00));
    send_item(make_req(MODE_UNUSED, snfcs_pkg::CMD_ERASE,
                       24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'h00, 8'hFF));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'h00, 8'h00));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'h00, 8'h81));
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ_ID,
                       24'h000000, 16'h0000, 8'h00, 8'h00));
    // Stray flash byte while idle.
    send_item(make_req(snfcs_pkg::MODE_FLASH, snfcs_pkg::CMD_READ,
                       24'h000000, 16'h0000, 8'h00, 8'h55));

    // Random command sequences, ending with the sequencer idle.
    rand_done = 0;
    step      = 0;
    while (rand_done < RANDOM_ITEMS || sb.phase != SEQ_IDLE) begin
      if (step == 40) begin
        // Result side holds off while items keep coming, so the queue fills.
        long_hold_req = 1'b1;
        eager_left    = 48;
      end else if (step == 110) begin
        wait_for_drain();
      end else if (step % 32 == 0 && $urandom_range(0, 2) == 0) begin
        eager_left = 16;
      end
      q = next_request();
      if (!sb.ignores(q.mode)) rand_done++;
      send_item(q);
      step++;
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d input transfers (%0d ignored) and %0d checked results.",
             sb.items, sb.ignored, sb.checked);
    $display("Commands: %0d read id, %0d read, %0d program, %0d erase; %0d busy polls.",
             sb.cmd_seen[snfcs_pkg::CMD_READ_ID], sb.cmd_seen[snfcs_pkg::CMD_READ],
             sb.cmd_seen[snfcs_pkg::CMD_PROGRAM], sb.cmd_seen[snfcs_pkg::CMD_ERASE],
             sb.busy_polls);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/snfcs_pkg.sv
hdl/spi_nor_flash_command_sequencer.sv
tb/sv/tb_top.sv
